/* hdl/modexp_pkg.sv */
// Shared types, constants and microprogram for the modular exponentiation block.
package modexp_pkg;

  localparam int DATA_W   = 32;
  localparam int EXP_BITS = 32;
  localparam int CNT_W    = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
  localparam int MUL_CNT_W = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] MODULUS_RESET = 32'd2130706433;

  typedef logic [2:0] pc_t;

  localparam pc_t PC_FETCH  = 3'd0;
  localparam pc_t PC_REDUCE = 3'd1;
  localparam pc_t PC_TEST   = 3'd2;
  localparam pc_t PC_MUL    = 3'd3;
  localparam pc_t PC_SQUARE = 3'd4;
  localparam pc_t PC_EMIT   = 3'd5;

  typedef enum logic {X_BASE, X_ACC} x_sel_t;
  typedef enum logic {Y_ONE, Y_BASE} y_sel_t;
  typedef enum logic {D_BASE, D_ACC} dest_t;
  typedef enum logic [1:0] {COND_NEVER, COND_ALWAYS, COND_BIT_CLEAR, COND_MORE} cond_t;

  typedef struct packed {
    logic   take_in;
    logic   mul;
    logic   shift;
    logic   emit;
    x_sel_t x_sel;
    y_sel_t y_sel;
    dest_t  dest;
    cond_t  cond;
    pc_t    target;
  } ctrl_word_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] product;
  } mul_rsp_t;

  function automatic ctrl_word_t ucode(input pc_t pc);
    ctrl_word_t cw;
    cw = '{take_in: 1'b0, mul: 1'b0, shift: 1'b0, emit: 1'b0, x_sel: X_BASE,
           y_sel: Y_ONE, dest: D_BASE, cond: COND_ALWAYS, target: PC_FETCH};
    case (pc)
      PC_FETCH: begin
        cw.take_in = 1'b1;
        cw.cond    = COND_NEVER;
      end
      PC_REDUCE: begin
        cw.mul   = 1'b1;
        cw.x_sel = X_BASE;
        cw.y_sel = Y_ONE;
        cw.dest  = D_BASE;
        cw.cond  = COND_NEVER;
      end
      PC_TEST: begin
        cw.cond   = COND_BIT_CLEAR;
        cw.target = PC_SQUARE;
      end
      PC_MUL: begin
        cw.mul   = 1'b1;
        cw.x_sel = X_ACC;
        cw.y_sel = Y_BASE;
        cw.dest  = D_ACC;
        cw.cond  = COND_NEVER;
      end
      PC_SQUARE: begin
        cw.mul    = 1'b1;
        cw.shift  = 1'b1;
        cw.x_sel  = X_BASE;
        cw.y_sel  = Y_BASE;
        cw.dest   = D_BASE;
        cw.cond   = COND_MORE;
        cw.target = PC_TEST;
      end
      PC_EMIT: begin
        cw.emit   = 1'b1;
        cw.cond   = COND_ALWAYS;
        cw.target = PC_FETCH;
      end
      default: begin
        cw.cond   = COND_ALWAYS;
        cw.target = PC_FETCH;
      end
    endcase
    return cw;
  endfunction

endpackage

/* hdl/modexp_mulmod.sv */
// Bit-serial interleaved multiply and reduce unit, one multiplier bit per cycle.
module modexp_mulmod
  import modexp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [DATA_W-1:0] modulus,
  input  mul_req_t          req,
  output mul_rsp_t          rsp
);

  logic                 busy;
  logic                 done;
  logic [MUL_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    xs;
  logic [DATA_W-1:0]    r;
  logic [DATA_W:0]      m_ext;
  logic [DATA_W:0]      dbl;
  logic [DATA_W:0]      red1;
  logic [DATA_W:0]      sum;
  logic [DATA_W:0]      red2;

  always_comb begin
    m_ext = {1'b0, modulus};
    dbl   = {r, 1'b0};
    red1  = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum   = red1 + (xs[DATA_W-1] ? {1'b0, req.y} : '0);
    red2  = (sum >= m_ext) ? sum - m_ext : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      xs <= req.x;
      r  <= '0;
    end else if (busy) begin
      xs <= {xs[DATA_W-2:0], 1'b0};
      r  <= red2[DATA_W-1:0];
    end
  end

  assign rsp.done    = done;
  assign rsp.product = r;

endmodule

/* hdl/modular_exponentiation.sv */
// Top level of the modular exponentiation block: microcoded sequencer and datapath.
//
// Computes base ** exponent mod modulus by right-to-left square-and-multiply.
// A six-word control program steps a small datapath through one base
// reduction and then, for each of the EXP_BITS exponent bits, an optional
// multiply into the accumulator and a squaring of the base. Every modular
// product comes from one shared bit-serial multiply-reduce unit, and the
// sequencer holds while it waits for a product, for input or for the
// output register. The next input is taken as soon as a result is loaded
// into the output register.
// A modulus of zero yields zero; write the modulus only while idle.
module modular_exponentiation
  import modexp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                modulus_wr_en,
  input  logic [DATA_W-1:0]   modulus_wr_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [2*DATA_W-1:0] s_tdata,   // base [31:0], exponent [63:32]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [DATA_W-1:0]   m_tdata    // power [31:0]
);

  logic [DATA_W-1:0] modulus;
  pc_t               pc;
  pc_t               pc_next;
  ctrl_word_t        cw;
  logic              issued;
  logic              stall;
  logic              jump;
  logic [DATA_W-1:0] base_reg;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] exp_reg;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] one;
  logic [DATA_W-1:0] power;
  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;

  modexp_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .req     (mul_req),
    .rsp     (mul_rsp)
  );

  always_comb begin
    cw    = ucode(pc);
    one   = (modulus == DATA_W'(1)) ? '0 : DATA_W'(1);
    stall = 1'b0;
    mul_req.start = 1'b0;
    mul_req.x = (cw.x_sel == X_ACC) ? acc : base_reg;
    mul_req.y = (cw.y_sel == Y_BASE) ? base_reg : one;
    if (cw.take_in && !s_tvalid) begin
      stall = 1'b1;
    end
    if (cw.mul) begin
      if (!issued) begin
        mul_req.start = 1'b1;
        stall = 1'b1;
      end else if (!mul_rsp.done) begin
        stall = 1'b1;
      end
    end
    if (cw.emit && m_tvalid && !m_tready) begin
      stall = 1'b1;
    end
    case (cw.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_BIT_CLEAR: jump = !exp_reg[0];
      COND_MORE:      jump = (cnt != CNT_W'(EXP_BITS - 1));
      default:        jump = 1'b0;
    endcase
    if (stall) begin
      pc_next = pc;
    end else if (jump) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  assign s_tready = cw.take_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= MODULUS_RESET;
      pc       <= PC_FETCH;
      issued   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (modulus_wr_en) begin
        modulus <= modulus_wr_data;
      end
      pc <= pc_next;
      if (mul_req.start) begin
        issued <= 1'b1;
      end else if (cw.mul && mul_rsp.done) begin
        issued <= 1'b0;
      end
      if (cw.emit && !stall) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cw.take_in && s_tvalid) begin
      base_reg <= s_tdata[DATA_W-1:0];
      exp_reg  <= s_tdata[2*DATA_W-1:DATA_W];
      acc      <= one;
      cnt      <= '0;
    end
    if (cw.mul && issued && mul_rsp.done) begin
      if (cw.dest == D_ACC) begin
        acc <= mul_rsp.product;
      end else begin
        base_reg <= mul_rsp.product;
      end
      if (cw.shift) begin
        exp_reg <= {1'b0, exp_reg[DATA_W-1:1]};
        cnt     <= cnt + 1'b1;
      end
    end
    if (cw.emit && !stall) begin
      power <= (modulus == '0) ? '0 : acc;
    end
  end

  assign m_tdata = power;

endmodule
